@@ rtl/efws_pkg.sv @@
package efws_pkg;

    localparam int MAX_WORKERS = 64;
    localparam int IDX_W       = $clog2(MAX_WORKERS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int TIME_W      = 64;
    localparam int DUR_W       = 32;

    // one heap entry: worker index and its next free time
    typedef struct packed {
        logic [TIME_W-1:0] free_time;
        logic [IDX_W-1:0]  worker;
    } t_entry;

    // input transaction
    typedef struct packed {
        logic [DUR_W-1:0] job_duration;
        logic             new_batch;
    } t_in;

    // output transaction
    typedef struct packed {
        logic [IDX_W-1:0]  worker_index;
        logic [TIME_W-1:0] start_time;
    } t_out;

endpackage

@@ rtl/efws_heap_ram.sv @@
module efws_heap_ram
    import efws_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic             i_re_a,
    input  logic [IDX_W-1:0] i_raddr_a,
    output t_entry           o_rdata_a,
    input  logic             i_re_b,
    input  logic [IDX_W-1:0] i_raddr_b,
    output t_entry           o_rdata_b
);

    t_entry                 r_mem [MAX_WORKERS];
    logic [MAX_WORKERS-1:0] r_valid;
    t_entry                 r_q_a;
    t_entry                 r_q_b;
    logic                   r_vld_a;
    logic                   r_vld_b;
    logic [IDX_W-1:0]       r_addr_a;
    logic [IDX_W-1:0]       r_addr_b;

    // store entries
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // track written entries; clear drops the whole heap back to its initial order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    // registered reads on both ports
    always_ff @(posedge i_clk) begin
        if (i_re_a) begin
            r_q_a    <= r_mem[i_raddr_a];
            r_vld_a  <= r_valid[i_raddr_a];
            r_addr_a <= i_raddr_a;
        end
        if (i_re_b) begin
            r_q_b    <= r_mem[i_raddr_b];
            r_vld_b  <= r_valid[i_raddr_b];
            r_addr_b <= i_raddr_b;
        end
    end

    // an entry never written holds worker k, free at time zero
    always_comb begin
        o_rdata_a = r_q_a;
        if (!r_vld_a) begin
            o_rdata_a.worker    = r_addr_a;
            o_rdata_a.free_time = '0;
        end
        o_rdata_b = r_q_b;
        if (!r_vld_b) begin
            o_rdata_b.worker    = r_addr_b;
            o_rdata_b.free_time = '0;
        end
    end

endmodule

@@ rtl/efws_cmp.sv @@
module efws_cmp
    import efws_pkg::*;
(
    input  t_entry i_a,
    input  t_entry i_b,
    output logic   o_a_first
);

    // earlier free time wins, equal times go to the lower worker index
    assign o_a_first = ({i_a.free_time, i_a.worker} < {i_b.free_time, i_b.worker});

endmodule

@@ rtl/earliest_free_worker_scheduler.sv @@
// Sequence: S_ROOT reads the root, S_LOAD registers the result once the output
// is free, then S_PICK and S_DECIDE walk one heap level each pass, ending in a write.
// A new job is taken only in S_IDLE, after the sift-down loop through the
// shared comparator and the heap memory read ports has finished.
// Reset: worker count 1, every worker free at time 0, no result pending.
module earliest_free_worker_scheduler
    import efws_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in              i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out             o_out_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ROOT   = 3'd1;
    localparam logic [2:0] S_LOAD   = 3'd2;
    localparam logic [2:0] S_PICK   = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CNT_W-1:0] r_wcount;
    logic [DUR_W-1:0] r_dur;
    t_entry           r_elem;
    t_entry           n_elem;
    logic [IDX_W-1:0] r_node;
    logic [IDX_W-1:0] n_node;
    t_entry           r_child;
    t_entry           n_child;
    logic [IDX_W-1:0] r_pick;
    logic [IDX_W-1:0] n_pick;
    logic             r_out_valid;
    logic             n_out_valid;
    t_out             r_out_data;
    t_out             n_out_data;

    logic [CNT_W-1:0] active_n;
    logic [CNT_W:0]   cnt_ext;
    logic [CNT_W:0]   left_idx;
    logic [CNT_W:0]   right_idx;
    logic [CNT_W:0]   next_left;
    logic             in_acc;
    logic             out_free;
    logic [TIME_W:0]  sum;
    logic [TIME_W-1:0] sat_time;

    logic             ram_clear;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_entry           ram_wdata;
    logic             ram_re_a;
    logic [IDX_W-1:0] ram_raddr_a;
    t_entry           ram_rdata_a;
    logic             ram_re_b;
    logic [IDX_W-1:0] ram_raddr_b;
    t_entry           ram_rdata_b;

    t_entry           cmp_a;
    t_entry           cmp_b;
    logic             cmp_a_first;

    efws_heap_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (ram_clear),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_re_a    (ram_re_a),
        .i_raddr_a (ram_raddr_a),
        .o_rdata_a (ram_rdata_a),
        .i_re_b    (ram_re_b),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_b (ram_rdata_b)
    );

    efws_cmp u_cmp (
        .i_a       (cmp_a),
        .i_b       (cmp_b),
        .o_a_first (cmp_a_first)
    );

    // clamp the worker count into 1..MAX_WORKERS
    always_comb begin
        if (r_wcount == '0) begin
            active_n = CNT_W'(1);
        end else if (r_wcount > CNT_W'(MAX_WORKERS)) begin
            active_n = CNT_W'(MAX_WORKERS);
        end else begin
            active_n = r_wcount;
        end
    end

    assign cnt_ext   = {1'b0, active_n};
    assign left_idx  = {1'b0, r_node, 1'b1};
    assign right_idx = left_idx + (CNT_W+1)'(1);
    assign next_left = {1'b0, r_pick, 1'b1};

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // saturating update of the root's free time
    assign sum      = {1'b0, ram_rdata_a.free_time} + (TIME_W+1)'(r_dur);
    assign sat_time = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

    assign ram_clear = in_acc && i_in_data.new_batch;

    // compare children while picking, then the moving entry against the child
    always_comb begin
        if (r_state == S_PICK) begin
            cmp_a = ram_rdata_a;
            cmp_b = ram_rdata_b;
        end else begin
            cmp_a = r_elem;
            cmp_b = r_child;
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_elem      = r_elem;
        n_node      = r_node;
        n_child     = r_child;
        n_pick      = r_pick;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_waddr   = r_node;
        ram_wdata   = r_elem;
        ram_re_a    = 1'b0;
        ram_raddr_a = '0;
        ram_re_b    = 1'b0;
        ram_raddr_b = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                ram_re_a = 1'b1;
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                // hand out the root, then start the sift-down from it
                if (out_free) begin
                    n_out_valid             = 1'b1;
                    n_out_data.worker_index = ram_rdata_a.worker;
                    n_out_data.start_time   = ram_rdata_a.free_time;
                    n_elem.worker           = ram_rdata_a.worker;
                    n_elem.free_time        = sat_time;
                    n_node                  = '0;
                    if ({(CNT_W+1)'(1)} >= cnt_ext) begin
                        n_state = S_FIN;
                    end else begin
                        ram_re_a    = 1'b1;
                        ram_raddr_a = IDX_W'(1);
                        ram_re_b    = 1'b1;
                        ram_raddr_b = IDX_W'(2);
                        n_state     = S_PICK;
                    end
                end
            end
            S_PICK: begin
                if (right_idx < cnt_ext && !cmp_a_first) begin
                    n_child = ram_rdata_b;
                    n_pick  = right_idx[IDX_W-1:0];
                end else begin
                    n_child = ram_rdata_a;
                    n_pick  = left_idx[IDX_W-1:0];
                end
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                ram_we = 1'b1;
                if (cmp_a_first) begin
                    // moving entry settles here
                    ram_wdata = r_elem;
                    n_state   = S_IDLE;
                end else begin
                    // lift the child and descend
                    ram_wdata = r_child;
                    n_node    = r_pick;
                    if (next_left >= cnt_ext) begin
                        n_state = S_FIN;
                    end else begin
                        ram_re_a    = 1'b1;
                        ram_raddr_a = next_left[IDX_W-1:0];
                        ram_re_b    = 1'b1;
                        ram_raddr_b = next_left[IDX_W-1:0] + IDX_W'(1);
                        n_state     = S_PICK;
                    end
                end
            end
            S_FIN: begin
                ram_we    = 1'b1;
                ram_wdata = r_elem;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_wcount    <= CNT_W'(1);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_wcount <= i_cfg_wdata;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_dur <= i_in_data.job_duration;
        end
        r_elem     <= n_elem;
        r_node     <= n_node;
        r_child    <= n_child;
        r_pick     <= n_pick;
        r_out_data <= n_out_data;
    end

endmodule

@@ tb/tb_earliest_free_worker_scheduler.sv @@
module tb_earliest_free_worker_scheduler
    import efws_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASES       = 9;
    localparam int PHASE_JOBS   = 50;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [CNT_W-1:0] i_cfg_wdata = '0;
    logic             i_in_valid  = 1'b0;
    t_in              i_in_data   = '0;
    logic             i_out_ready = 1'b0;
    logic             o_in_ready;
    logic             o_out_valid;
    t_out             o_out_data;

    earliest_free_worker_scheduler uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predicted heap of (worker, next free time) and active worker count
    logic [IDX_W-1:0]  sched_worker [MAX_WORKERS];
    logic [TIME_W-1:0] sched_free   [MAX_WORKERS];
    logic [CNT_W-1:0]  sched_count;

    t_in  pending_jobs[$];
    t_out assignments_due[$];

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_seq      = 0;
    int   hold_seen     = 0;
    int   hold_left     = 0;
    bit   in_taken      = 1'b0;
    int   errors        = 0;
    int   jobs_done     = 0;
    int   batches_seen  = 0;
    int   settings_used = 0;
    int   cycles        = 0;

    // Put every worker back at time zero, entry k holding worker k
    function automatic void restart_all();
        for (int k = 0; k < MAX_WORKERS; k++) begin
            sched_worker[k] = k[IDX_W-1:0];
            sched_free[k]   = '0;
        end
    endfunction

    // Earlier free time wins, lower worker index breaks ties
    function automatic bit ahead_of(int a, int b);
        if (sched_free[a] != sched_free[b])
            return sched_free[a] < sched_free[b];
        return sched_worker[a] < sched_worker[b];
    endfunction

    // Push the root down until it is ahead of its preferred child
    function automatic void sift_root(int n);
        int                node;
        int                left;
        int                right;
        int                pick;
        logic [IDX_W-1:0]  w;
        logic [TIME_W-1:0] t;
        node = 0;
        while (2 * node + 1 < n) begin
            left  = 2 * node + 1;
            right = 2 * node + 2;
            pick  = (right >= n || ahead_of(left, right)) ? left : right;
            if (ahead_of(node, pick))
                break;
            w                  = sched_worker[node];
            t                  = sched_free[node];
            sched_worker[node] = sched_worker[pick];
            sched_free[node]   = sched_free[pick];
            sched_worker[pick] = w;
            sched_free[pick]   = t;
            node               = pick;
        end
    endfunction

    // Restart on a new batch, hand the job to the root worker, then charge its duration and re-heap
    function automatic t_out schedule_job(t_in job);
        t_out            res;
        logic [TIME_W:0] sum;
        int              n;
        if (sched_count == 0)
            n = 1;
        else if (sched_count > MAX_WORKERS)
            n = MAX_WORKERS;
        else
            n = int'(sched_count);
        if (job.new_batch)
            restart_all();
        res.worker_index = sched_worker[0];
        res.start_time   = sched_free[0];
        sum              = {1'b0, sched_free[0]} + (TIME_W+1)'(job.job_duration);
        sched_free[0]    = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
        sift_root(n);
        return res;
    endfunction

    // Offer the next pending job; hold valid and payload until accepted
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (pending_jobs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_jobs.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Throttle the result side; a new hold request stalls it for a long stretch
    always @(negedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Track config writes, check results, predict accepted jobs
    always @(posedge i_clk) begin : monitor
        t_out want;
        in_taken = 1'b0;
        if (!i_rst_n) begin
            restart_all();
            sched_count = CNT_W'(1);
            assignments_due.delete();
        end else begin
            if (i_cfg_we)
                sched_count = i_cfg_wdata;
            if (o_out_valid && i_out_ready) begin
                if (assignments_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result worker %0d start %0d", $time,
                             o_out_data.worker_index, o_out_data.start_time);
                end else begin
                    want = assignments_due.pop_front();
                    if (o_out_data.worker_index !== want.worker_index) begin
                        errors++;
                        $display("%0t: worker_index expected %0d, got %0d", $time,
                                 want.worker_index, o_out_data.worker_index);
                    end
                    if (o_out_data.start_time !== want.start_time) begin
                        errors++;
                        $display("%0t: start_time expected %0d, got %0d", $time,
                                 want.start_time, o_out_data.start_time);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                in_taken = 1'b1;
                jobs_done++;
                if (i_in_data.new_batch)
                    batches_seen++;
                assignments_due = {assignments_due, schedule_job(i_in_data)};
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, assignments_due.size());
            $display("earliest_free_worker_scheduler test failed");
            $finish;
        end
    end

    // Wait until no job is queued or in flight, then let the heap update settle
    task automatic drain();
        do
            @(posedge i_clk);
        while (pending_jobs.size() != 0 || i_in_valid || assignments_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_workers(int value);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CNT_W'(value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    task automatic add_job(logic [DUR_W-1:0] dur, logic batch);
        t_in job;
        job.job_duration = dur;
        job.new_batch    = batch;
        pending_jobs     = {pending_jobs, job};
    endtask

    // Favor short durations so ties and reordering happen often
    task automatic add_random_job();
        int               pick;
        logic [DUR_W-1:0] dur;
        pick = $urandom_range(99);
        if (pick < 40)
            dur = $urandom_range(20);
        else if (pick < 60)
            dur = $urandom_range(1000);
        else if (pick < 85)
            dur = $urandom();
        else if (pick < 95)
            dur = '1;
        else
            dur = '0;
        add_job(dur, $urandom_range(24) == 0);
    endtask

    initial begin
        int counts[PHASES];
        counts        = '{7, 64, 2, 16, 127, 3, 65, 0, 33};
        send_idle_pct = 9;
        recv_idle_pct = 55;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single worker from reset: large durations, zero duration, rebuild
        add_job('1, 1'b0);
        add_job('1, 1'b0);
        add_job('0, 1'b0);
        add_job(5, 1'b1);
        add_job(7, 1'b0);

        // zero count behaves as one worker
        set_workers(0);
        add_job(32'h8000_0000, 1'b0);
        add_job(32'h7FFF_FFFF, 1'b0);
        add_job(1, 1'b1);

        // count above capacity clamps to the full heap
        set_workers(127);
        add_job(0, 1'b1);
        add_job(0, 1'b0);
        add_job(3, 1'b0);
        add_job('1, 1'b0);

        // small heap with equal free times
        set_workers(5);
        add_job(10, 1'b1);
        add_job(3, 1'b0);
        add_job(3, 1'b0);
        add_job(0, 1'b0);
        add_job(12, 1'b0);

        // shrink and then grow the count without a rebuild
        set_workers(2);
        add_job(4, 1'b0);
        add_job(4, 1'b0);
        set_workers(64);
        add_job(1, 1'b0);
        add_job(2, 1'b0);
        add_job(32'hAAAA_5555, 1'b0);

        // random phases across worker counts and idle patterns
        for (int p = 0; p < PHASES; p++) begin
            set_workers(counts[p]);
            if (p < 3) begin
                send_idle_pct = 9;
                recv_idle_pct = 55;
            end else if (p < 6) begin
                send_idle_pct = 55;
                recv_idle_pct = 9;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            add_job($urandom(), 1'($urandom_range(1)));
            for (int j = 1; j < PHASE_JOBS; j++)
                add_random_job();
            // stall the result side while jobs keep coming
            if (p == 6)
                hold_seq++;
        end
        drain();

        $display("Ran %0d jobs (%0d starting a new batch) over %0d worker-count settings",
                 jobs_done, batches_seen, settings_used);
        if (errors == 0 && assignments_due.size() == 0) begin
            $display("earliest_free_worker_scheduler test passed");
        end else begin
            $display("%0d mismatches, %0d results outstanding", errors, assignments_due.size());
            $display("earliest_free_worker_scheduler test failed");
        end
        $finish;
    end

endmodule

@@ earliest_free_worker_scheduler.f @@
rtl/efws_pkg.sv
rtl/efws_heap_ram.sv
rtl/efws_cmp.sv
rtl/earliest_free_worker_scheduler.sv
tb/tb_earliest_free_worker_scheduler.sv
